// ----- src/bst_pkg.sv -----
// Shared types and constants for the bounded set table.
package bst_pkg;

  // Fixed widths of the stream fields.
  localparam int ELEM_BITS  = 32;
  localparam int POS_BITS   = 4;
  localparam int COUNT_BITS = 5;
  localparam int IN_BITS    = 40;
  localparam int OUT_BITS   = 40;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_READ     = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FETCH,
    ST_RESOLVE
  } state_t;

endpackage

// ----- src/bst_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bounded_set_table.sv -----
// Top level of the bounded set table: sequencer, comparator and result register.
// Steps: a read at a valid index passes through the fetch step to the resolve step, any other
// read goes straight to resolve; add, remove and contains scan the stored entries one by one,
// and a remove of a stored entry then shifts the later entries one place down. The resolve
// step waits while the result register holds a result that has not yet been taken.
// Throughput: one item at a time; the single RAM read port visits one table entry per cycle
// during the search and during the compaction shift.
// Reset (synchronous, active high) empties the table by clearing the count; no clearing
// pass is made over the RAM, whose contents stay undefined until written.
module bounded_set_table
  import bst_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  // Input item stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // element [31:0], position [35:32], zeros above
  input  logic [1:0]          s_tuser,   // action [1:0]
  // Result item stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata    // success [0], table_full [1], read_value [33:2],
                                         // entry_count [38:34], zero [39]
);

  // Address width of the table and width of a counter that can hold CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  // Latched item.
  act_t                     act;
  logic [ELEMENT_WIDTH-1:0] key;
  logic [POS_BITS-1:0]      pos;
  logic                     pos_ok;

  // Table occupancy and walk state.
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // next entry to read
  logic [AW-1:0] cmp_idx;   // entry whose data is on the RAM output
  logic          pend;      // RAM output holds entry cmp_idx
  logic          found;

  // Result register, which parts the result stream from the sequencer.
  logic                  out_success;
  logic                  out_full;
  logic [ELEM_BITS-1:0]  out_value;
  logic [COUNT_BITS-1:0] out_count;

  // RAM port signals.
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  // Decoded input fields; element bits above ELEMENT_WIDTH are dropped.
  logic [ELEMENT_WIDTH-1:0] in_key;
  logic [POS_BITS-1:0]      in_pos;
  act_t                     in_act;

  // Sequencer status and result values.
  logic                  accept;
  logic                  issue;
  logic                  hit;
  logic                  miss_done;
  logic                  out_free;
  logic                  load;
  logic                  res_success;
  logic                  res_full;
  logic [ELEM_BITS-1:0]  res_value;
  logic [CW-1:0]         res_count;

  assign in_key = ELEMENT_WIDTH'(64'(s_tdata[ELEM_BITS-1:0]));
  assign in_pos = s_tdata[ELEM_BITS +: POS_BITS];
  assign in_act = act_t'(s_tuser);

  // An item is taken whenever the sequencer is idle, even while a previous result
  // still waits in the output register.
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // The comparator: the single shared unit checks one entry per cycle against the key.
  assign hit       = (state == ST_SCAN) && pend && (ram_rdata == key);
  assign miss_done = (state == ST_SCAN) && pend && !hit && (idx >= count);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_act == ACT_READ) begin
            state_next = (32'(in_pos) < 32'(count)) ? ST_FETCH : ST_RESOLVE;
          end else begin
            state_next = (count == '0) ? ST_RESOLVE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (act == ACT_REMOVE) ? ST_SHIFT : ST_RESOLVE;
        end else if (miss_done) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_SHIFT: begin
        if (idx >= count) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_FETCH: begin
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: RAM control and the result of the finished item.
  always_comb begin
    issue       = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(idx);
    ram_we      = 1'b0;
    ram_waddr   = AW'(cmp_idx - 1'b1);
    ram_wdata   = ram_rdata;
    load        = 1'b0;
    res_success = 1'b0;
    res_full    = 1'b0;
    res_value   = '0;
    res_count   = count;

    unique case (act)
      ACT_ADD: begin
        res_success = !found && (count < CW'(CAPACITY));
        res_full    = !found && (count >= CW'(CAPACITY));
        res_count   = count + CW'(res_success);
      end
      ACT_REMOVE: begin
        res_success = found;
        res_count   = count - CW'(found);
      end
      ACT_CONTAINS: begin
        res_success = found;
      end
      ACT_READ: begin
        res_success = pos_ok;
        res_value   = pos_ok ? ELEM_BITS'(64'(ram_rdata)) : '0;
      end
      default: begin
        res_success = 1'b0;
      end
    endcase

    unique case (state)
      ST_SCAN: begin
        issue  = (idx < count);
        ram_re = issue;
      end
      ST_SHIFT: begin
        // Read entry idx while writing the entry fetched last cycle one place lower.
        issue  = (idx < count);
        ram_re = issue;
        ram_we = pend;
      end
      ST_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(pos);
      end
      ST_RESOLVE: begin
        load = out_free;
        // A new entry is appended at the end of the table.
        if ((act == ACT_ADD) && res_success) begin
          ram_we    = load;
          ram_waddr = AW'(count);
          ram_wdata = key;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (hit && (act == ACT_REMOVE)) begin
        // Compaction starts with the entry just above the one found.
        idx  <= CW'(cmp_idx) + 1'b1;
        pend <= 1'b0;
      end else begin
        pend <= issue;
        if (issue) begin
          idx     <= idx + 1'b1;
          cmp_idx <= AW'(idx);
        end
      end
      if (accept) begin
        act    <= in_act;
        key    <= in_key;
        pos    <= in_pos;
        pos_ok <= (32'(in_pos) < 32'(count));
        idx    <= '0;
        found  <= 1'b0;
      end
      if (hit) begin
        found <= 1'b1;
      end
      if (load) begin
        count <= res_count;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_success <= res_success;
      out_full    <= res_full;
      out_value   <= res_value;
      out_count   <= COUNT_BITS'(res_count);
    end
  end

  assign m_tdata = {1'b0, out_count, out_value, out_full, out_success};

  bst_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A result appears only after the resolve step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESOLVE))
    else $error("result raised outside the resolve step");

  // The table is never written while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // The count changes only when a result is loaded.
  assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> $past(load))
    else $error("entry count changed without a result");

endmodule
